// File: src/fov_pkg.sv
// Shared types, widths, register indexes and defaults for the lidar field-of-view filter.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fov_pkg;

   // Default image size and crop box limits (metres).
   localparam int DEF_IMAGE_WIDTH   = 1242;
   localparam int DEF_IMAGE_HEIGHT  = 375;
   localparam int DEF_MAX_FORWARD_M = 70;
   localparam int DEF_MAX_LATERAL_M = 40;

   // Field and arithmetic widths.
   localparam int PT_W   = 16;          // Q8.8 point coordinate
   localparam int COEF_W = 32;          // Q16.16 coefficient
   localparam int PROD_W = PT_W + COEF_W;   // exact Q24.24 product
   localparam int SUM_W  = PROD_W + 2;      // three products plus translation
   localparam int CSR_W  = 64;
   localparam int IDX_W  = 3;
   localparam int NUM_CSR = 6;          // 64-bit matrix registers

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_ROW0_AB      = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROW0_CD      = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROW1_AB      = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROW1_CD      = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROW2_AB      = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROW2_CD      = 3'd5;
   localparam logic [IDX_W-1:0] REG_DEPTH_OFFSET = 3'd6;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [3:0]           row_type;
   typedef row_type [2:0]            matrix_type;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef prod_type [2:0]           prod_row_type;
   typedef prod_row_type [2:0]       prod_mat_type;

   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef sum_type [2:0]            sum_vec_type;

   typedef struct packed {
      logic signed [PT_W-1:0] x;
      logic signed [PT_W-1:0] y;
      logic signed [PT_W-1:0] z;
      logic [PT_W-1:0]        intensity;
   } point_type;

   typedef struct packed {
      logic      in_view;
      point_type point;
   } result_type;

   // Sign extension of a product to the row sum width.
   function automatic sum_type prod_to_sum(input prod_type p);
      return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

   // Translation coefficient scaled by 256 into Q24.24, extended to the row sum width.
   function automatic sum_type trans_to_sum(input coef_type c);
      return {{(SUM_W - COEF_W - 8){c[COEF_W-1]}}, c, 8'b0};
   endfunction

endpackage

`default_nettype wire

// File: src/fov_req_if.sv
// Point channel: valid/ready handshake carrying one lidar point per word.
// Depends on fov_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fov_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [fov_pkg::PT_W-1:0]  point_x;
   logic signed [fov_pkg::PT_W-1:0]  point_y;
   logic signed [fov_pkg::PT_W-1:0]  point_z;
   logic [fov_pkg::PT_W-1:0]         point_intensity;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output point_intensity, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   input point_intensity, output ready);
endinterface

`default_nettype wire

// File: src/fov_rsp_if.sv
// Result channel: valid/ready handshake carrying the view flag and the point copy.
// Depends on fov_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fov_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             in_view;
   logic signed [fov_pkg::PT_W-1:0]  out_x;
   logic signed [fov_pkg::PT_W-1:0]  out_y;
   logic signed [fov_pkg::PT_W-1:0]  out_z;
   logic [fov_pkg::PT_W-1:0]         out_intensity;

   modport source (output valid, output in_view, output out_x, output out_y, output out_z,
                   output out_intensity, input ready);
   modport sink   (input valid, input in_view, input out_x, input out_y, input out_z,
                   input out_intensity, output ready);
endinterface

`default_nettype wire

// File: src/fov_mult.sv
// First pipeline stage: crop box test and the nine coefficient-by-coordinate products.
// Depends on fov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fov_mult #(
   parameter int MAX_FORWARD_M = fov_pkg::DEF_MAX_FORWARD_M,
   parameter int MAX_LATERAL_M = fov_pkg::DEF_MAX_LATERAL_M
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire fov_pkg::point_type    in_point,
   input  wire fov_pkg::matrix_type   matrix,
   output logic                       out_valid,
   output fov_pkg::point_type         out_point,
   output logic                       out_crop,
   output fov_pkg::prod_mat_type      out_prod
);

   localparam int LIM_W = fov_pkg::PT_W + 2;
   localparam logic signed [LIM_W-1:0] FWD_LIM = LIM_W'(MAX_FORWARD_M * 256);
   localparam logic signed [LIM_W-1:0] LAT_LIM = LIM_W'(MAX_LATERAL_M * 256);
   localparam logic signed [LIM_W-1:0] LAT_NEG = LIM_W'(-(MAX_LATERAL_M * 256));

   logic signed [LIM_W-1:0] x_ext;
   logic signed [LIM_W-1:0] y_ext;
   logic                    crop_in;
   fov_pkg::prod_mat_type   prod_in;

   logic                    valid_ff;
   fov_pkg::point_type      point_ff;
   logic                    crop_ff;
   fov_pkg::prod_mat_type   prod_ff;

   // Crop box: forward in [0, max], lateral in [-max, max], edges included.
   assign x_ext   = {{2{in_point.x[fov_pkg::PT_W-1]}}, in_point.x};
   assign y_ext   = {{2{in_point.y[fov_pkg::PT_W-1]}}, in_point.y};
   assign crop_in = !in_point.x[fov_pkg::PT_W-1] && (x_ext <= FWD_LIM) &&
                    (y_ext <= LAT_LIM) && (y_ext >= LAT_NEG);

   // One 32x16 signed multiplier for each of the three linear coefficients of each row.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = matrix[r][0] * in_point.x;
         prod_in[r][1] = matrix[r][1] * in_point.y;
         prod_in[r][2] = matrix[r][2] * in_point.z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         point_ff <= in_point;
         crop_ff  <= crop_in;
         prod_ff  <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_point = point_ff;
   assign out_crop  = crop_ff;
   assign out_prod  = prod_ff;

endmodule

`default_nettype wire

// File: src/fov_row_sum.sv
// Second pipeline stage: adds the products and the scaled translation of each row into u, v, w.
// Depends on fov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fov_row_sum (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire fov_pkg::point_type     in_point,
   input  wire logic                   in_crop,
   input  wire fov_pkg::prod_mat_type  in_prod,
   input  wire fov_pkg::matrix_type    matrix,
   output logic                        out_valid,
   output fov_pkg::point_type          out_point,
   output logic                        out_crop,
   output fov_pkg::sum_vec_type        out_sum
);

   fov_pkg::sum_vec_type sum_in;

   logic                 valid_ff;
   fov_pkg::point_type   point_ff;
   logic                 crop_ff;
   fov_pkg::sum_vec_type sum_ff;

   // Exact Q24.24 row sums; the width leaves room so nothing wraps.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = fov_pkg::prod_to_sum(in_prod[r][0]) +
                     fov_pkg::prod_to_sum(in_prod[r][1]) +
                     fov_pkg::prod_to_sum(in_prod[r][2]) +
                     fov_pkg::trans_to_sum(matrix[r][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         point_ff <= in_point;
         crop_ff  <= in_crop;
         sum_ff   <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_point = point_ff;
   assign out_crop  = crop_ff;
   assign out_sum   = sum_ff;

endmodule

`default_nettype wire

// File: src/fov_view_check.sv
// Third and fourth pipeline stages: image bounds scaled by w, sign and depth tests,
// then the final compares into the output register. Depends on fov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fov_view_check #(
   parameter int IMAGE_WIDTH  = fov_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = fov_pkg::DEF_IMAGE_HEIGHT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en_scale,
   input  wire logic                        en_out,
   input  wire logic                        in_valid,
   input  wire fov_pkg::point_type          in_point,
   input  wire logic                        in_crop,
   input  wire fov_pkg::sum_vec_type        in_sum,
   input  wire fov_pkg::coef_type           depth_offset,
   output logic                             mid_valid,
   output logic                             out_valid,
   output fov_pkg::result_type              out_result
);

   localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
   localparam int DIM_W   = $clog2(DIM_MAX + 1) + 1;
   localparam int LIM_W   = fov_pkg::SUM_W + DIM_W;
   localparam int DEP_W   = fov_pkg::SUM_W + 1;
   localparam logic signed [DIM_W-1:0] WIDTH_S  = DIM_W'(IMAGE_WIDTH);
   localparam logic signed [DIM_W-1:0] HEIGHT_S = DIM_W'(IMAGE_HEIGHT);

   fov_pkg::sum_type         u;
   fov_pkg::sum_type         v;
   fov_pkg::sum_type         w;
   logic signed [LIM_W-1:0]  w_ext;
   logic signed [LIM_W-1:0]  u_lim_in;
   logic signed [LIM_W-1:0]  v_lim_in;
   logic signed [DEP_W-1:0]  depth;
   logic                     pre_ok_in;
   logic signed [LIM_W-1:0]  u_ext;
   logic signed [LIM_W-1:0]  v_ext;
   logic                     view_in;

   logic                     mid_valid_ff;
   fov_pkg::point_type       mid_point_ff;
   logic                     pre_ok_ff;
   fov_pkg::sum_type         u_ff;
   fov_pkg::sum_type         v_ff;
   logic signed [LIM_W-1:0]  u_lim_ff;
   logic signed [LIM_W-1:0]  v_lim_ff;

   logic                     out_valid_ff;
   fov_pkg::result_type      result_ff;

   assign u = in_sum[0];
   assign v = in_sum[1];
   assign w = in_sum[2];

   // Pixel bounds without a divide: width * w and height * w by constant multipliers.
   assign w_ext    = {{DIM_W{w[fov_pkg::SUM_W-1]}}, w};
   assign u_lim_in = w_ext * WIDTH_S;
   assign v_lim_in = w_ext * HEIGHT_S;

   // Depth is w less the offset scaled into Q24.24.
   assign depth = {w[fov_pkg::SUM_W-1], w} -
                  DEP_W'(fov_pkg::trans_to_sum(depth_offset));

   // Everything but the two bound compares is settled in this stage.
   assign pre_ok_in = in_crop && !w[fov_pkg::SUM_W-1] && (w != '0) &&
                      !u[fov_pkg::SUM_W-1] && !v[fov_pkg::SUM_W-1] &&
                      !depth[DEP_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (en_scale) begin
         mid_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_scale && in_valid) begin
         mid_point_ff <= in_point;
         pre_ok_ff    <= pre_ok_in;
         u_ff         <= u;
         v_ff         <= v;
         u_lim_ff     <= u_lim_in;
         v_lim_ff     <= v_lim_in;
      end
   end

   // Final compares of u and v against the scaled image size.
   assign u_ext   = {{DIM_W{u_ff[fov_pkg::SUM_W-1]}}, u_ff};
   assign v_ext   = {{DIM_W{v_ff[fov_pkg::SUM_W-1]}}, v_ff};
   assign view_in = pre_ok_ff && (u_ext < u_lim_ff) && (v_ext < v_lim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && mid_valid_ff) begin
         result_ff.in_view <= view_in;
         result_ff.point   <= mid_point_ff;
      end
   end

   assign mid_valid  = mid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// File: src/lidar_camera_fov_filter.sv
// Top level of the lidar field-of-view filter: configuration registers, stage handshake
// and the four pipeline stages. Depends on fov_pkg, fov_req_if, fov_rsp_if and the stage modules.
//
//  Channel   Direction  Payload                                       Handshake
//  req_ch    in         point_x, point_y, point_z, point_intensity    valid / ready
//  rsp_ch    out        in_view, out_x, out_y, out_z, out_intensity   valid / ready
//  csr_*     in         csr_index (3 bits), csr_wdata (64 bits)       csr_we, no stall
//
//  One point is taken every cycle while the first stage can load; a held result can stall it.
//  The stages are multiply, row sum, bound scaling and final compare (the output register).
//  Each stage advances when it is empty or the stage after it advances, so a held result
//  stalls only the stages behind it that are full; bubbles are squeezed out.
//  Reset clears the stage valid bits and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module lidar_camera_fov_filter #(
   parameter int IMAGE_WIDTH   = fov_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT  = fov_pkg::DEF_IMAGE_HEIGHT,
   parameter int MAX_FORWARD_M = fov_pkg::DEF_MAX_FORWARD_M,
   parameter int MAX_LATERAL_M = fov_pkg::DEF_MAX_LATERAL_M
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   fov_req_if.sink                          req_ch,
   fov_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_we,
   input  wire logic [fov_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [fov_pkg::CSR_W-1:0]   csr_wdata
);

   logic [fov_pkg::CSR_W-1:0] mat_ff [fov_pkg::NUM_CSR];
   fov_pkg::coef_type         offset_ff;
   fov_pkg::matrix_type       matrix;

   fov_pkg::point_type        req_point;
   logic                      en1, en2, en3, en4;
   logic                      v1, v2, v3, v4;
   fov_pkg::point_type        p1, p2;
   logic                      crop1, crop2;
   fov_pkg::prod_mat_type     prod1;
   fov_pkg::sum_vec_type      sum2;
   fov_pkg::result_type       result;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fov_pkg::NUM_CSR; i++) begin
            mat_ff[i] <= '0;
         end
         offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fov_pkg::REG_ROW0_AB:      mat_ff[0] <= csr_wdata;
            fov_pkg::REG_ROW0_CD:      mat_ff[1] <= csr_wdata;
            fov_pkg::REG_ROW1_AB:      mat_ff[2] <= csr_wdata;
            fov_pkg::REG_ROW1_CD:      mat_ff[3] <= csr_wdata;
            fov_pkg::REG_ROW2_AB:      mat_ff[4] <= csr_wdata;
            fov_pkg::REG_ROW2_CD:      mat_ff[5] <= csr_wdata;
            fov_pkg::REG_DEPTH_OFFSET: offset_ff <= csr_wdata[fov_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // Unpack the matrix words: upper half is the first coefficient of each pair.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         matrix[r][0] = mat_ff[2*r][63:32];
         matrix[r][1] = mat_ff[2*r][31:0];
         matrix[r][2] = mat_ff[2*r+1][63:32];
         matrix[r][3] = mat_ff[2*r+1][31:0];
      end
   end

   // Stage enables: a stage loads when it is empty or its successor loads.
   assign en4 = !v4 || rsp_ch.ready;
   assign en3 = !v3 || en4;
   assign en2 = !v2 || en3;
   assign en1 = !v1 || en2;
   assign req_ch.ready = en1;

   assign req_point.x         = req_ch.point_x;
   assign req_point.y         = req_ch.point_y;
   assign req_point.z         = req_ch.point_z;
   assign req_point.intensity = req_ch.point_intensity;

   fov_mult #(
      .MAX_FORWARD_M (MAX_FORWARD_M),
      .MAX_LATERAL_M (MAX_LATERAL_M)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .en        (en1),
      .in_valid  (req_ch.valid),
      .in_point  (req_point),
      .matrix    (matrix),
      .out_valid (v1),
      .out_point (p1),
      .out_crop  (crop1),
      .out_prod  (prod1)
   );

   fov_row_sum u_row_sum (
      .clock     (clock),
      .reset     (reset),
      .en        (en2),
      .in_valid  (v1),
      .in_point  (p1),
      .in_crop   (crop1),
      .in_prod   (prod1),
      .matrix    (matrix),
      .out_valid (v2),
      .out_point (p2),
      .out_crop  (crop2),
      .out_sum   (sum2)
   );

   fov_view_check #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_view_check (
      .clock        (clock),
      .reset        (reset),
      .en_scale     (en3),
      .en_out       (en4),
      .in_valid     (v2),
      .in_point     (p2),
      .in_crop      (crop2),
      .in_sum       (sum2),
      .depth_offset (offset_ff),
      .mid_valid    (v3),
      .out_valid    (v4),
      .out_result   (result)
   );

   assign rsp_ch.valid         = v4;
   assign rsp_ch.in_view       = result.in_view;
   assign rsp_ch.out_x         = result.point.x;
   assign rsp_ch.out_y         = result.point.y;
   assign rsp_ch.out_z         = result.point.z;
   assign rsp_ch.out_intensity = result.point.intensity;

   // A point reported in view must lie inside the crop box.
   a_view_in_crop: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.in_view) |->
         (!rsp_ch.out_x[fov_pkg::PT_W-1] &&
          ($signed({2'b00, rsp_ch.out_x}) <= $signed(18'(MAX_FORWARD_M * 256))) &&
          ($signed({{2{rsp_ch.out_y[fov_pkg::PT_W-1]}}, rsp_ch.out_y}) <=
           $signed(18'(MAX_LATERAL_M * 256))) &&
          ($signed({{2{rsp_ch.out_y[fov_pkg::PT_W-1]}}, rsp_ch.out_y}) >=
           $signed(18'(-(MAX_LATERAL_M * 256))))))
      else $error("in-view point outside crop box");

   // A full pipeline behind a held result takes no new point.
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (v1 && v2 && v3 && v4 && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("point accepted while pipeline full and stalled");

   // A taken point with nothing leaving leaves at least one stage occupied.
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !(rsp_ch.valid && rsp_ch.ready)) |=>
         ($countones({v1, v2, v3, v4}) >= 1))
      else $error("accepted point lost from pipeline");

   // Nothing is offered in the first cycle after reset is released.
   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
